FILE: rtl/ccw_pkg.sv
// shared types, codes and default sizes for the coin change ways counter
package ccw_pkg;

  // default sizes
  localparam int unsigned MAX_AMOUNT_DEF  = 4096;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned COIN_WIDTH_DEF  = 16;

  // fixed field widths
  localparam int unsigned OPERAND_W = 16;
  localparam int unsigned WAYS_W    = 32;
  // compare width that holds any operand and any amount
  localparam int unsigned CMP_W     = OPERAND_W + 1;
  // width a table count is extended to before the result clip
  localparam int unsigned EXT_W     = 64;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_COIN  = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [OPERAND_W-1:0] operand_value;
    logic                 last_item;
  } req_t;

  typedef struct packed {
    logic [WAYS_W-1:0] ways;
    logic              saturated;
  } rsp_t;

endpackage

FILE: rtl/ccw_ram.sv
// generic ram: one write port, two registered read ports
module ccw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4097,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: rtl/ccw_sat_add.sv
// saturating unsigned adder shared by every table update
module ccw_sat_add #(
  parameter int unsigned WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] sum,
  output logic             ovf
);

  logic [WIDTH:0] full;

  assign full = {1'b0, a} + {1'b0, b};
  assign ovf  = full[WIDTH];
  assign sum  = ovf ? {WIDTH{1'b1}} : full[WIDTH-1:0];

endmodule

FILE: rtl/coin_change_ways_counter.sv
// top level of the coin change ways counter
//
// counts the unordered ways to reach a target amount from an unlimited supply
// of coin values. a start item sets the amount (clipped to MAX_AMOUNT) and
// sweeps table entries 0..amount, one per cycle, writing one to entry 0 and
// zero elsewhere. a coin item with a value in 1..amount walks entries
// coin..amount, one per cycle through the single table write port, then
// flushes its last update; any other coin value is a no-op. an item with
// last_item set then reads table[amount] and pulses done for exactly one cycle
// with the result on rsp. the receiver cannot stall: rsp is valid only in the
// done cycle. busy is high after the transfer until the item is finished
// (including the done cycle); start is taken only while busy is low. counts
// saturate at COUNT_WIDTH bits and set a sticky flag cleared only by a start
// item or reset. a coin item before any start item is a no-op, as reset clears
// the amount; a last item before any start item reads an unwritten entry and
// gives no defined answer.
module coin_change_ways_counter #(
  parameter int unsigned MAX_AMOUNT  = ccw_pkg::MAX_AMOUNT_DEF,
  parameter int unsigned COUNT_WIDTH = ccw_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned COIN_WIDTH  = ccw_pkg::COIN_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ccw_pkg::req_t req,
  output logic          done,
  output ccw_pkg::rsp_t rsp
);
  import ccw_pkg::*;

  localparam int unsigned DEPTH = MAX_AMOUNT + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // coin field after masking to COIN_WIDTH bits
  localparam logic [OPERAND_W-1:0] COIN_MASK = (COIN_WIDTH >= OPERAND_W) ?
      {OPERAND_W{1'b1}} : OPERAND_W'((64'd1 << COIN_WIDTH) - 64'd1);
  localparam logic [CMP_W-1:0] MAX_AMT_X = CMP_W'(MAX_AMOUNT);

  // one-hot sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLEAR = 6'b000010,
    S_PASS  = 6'b000100,
    S_FLUSH = 6'b001000,
    S_READ  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  // control registers
  logic [AW-1:0]    target;      // clipped amount
  logic [AW-1:0]    coin;        // coin of the running pass
  logic [AW-1:0]    idx;         // sweep / read-issue index
  logic             last_pend;   // emit a result after this item
  logic             ovf_seen;    // sticky saturation flag

  // update pipeline: entry whose operands arrive this cycle
  logic             s1_valid;
  logic [AW-1:0]    s1_idx;
  logic             s1_fwd;      // low operand is the entry written last cycle
  logic [COUNT_WIDTH-1:0] last_wdata;

  // table port signals
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [AW-1:0]          raddr_a;
  logic [AW-1:0]          raddr_b;
  logic [COUNT_WIDTH-1:0] rdata_a;
  logic [COUNT_WIDTH-1:0] rdata_b;

  // adder signals
  logic [COUNT_WIDTH-1:0] lo_op;
  logic [COUNT_WIDTH-1:0] sum;
  logic                   sum_ovf;

  // input decode
  logic                   take;
  logic [CMP_W-1:0]       val_x;
  logic [CMP_W-1:0]       amt_x;
  logic [CMP_W-1:0]       coin_x;
  logic                   coin_ok;

  // result formatting
  logic [EXT_W-1:0]       rd_ext;
  logic                   clip;

  assign busy    = (state != S_IDLE);
  assign take    = start && !busy;
  assign val_x   = CMP_W'(req.operand_value);
  assign amt_x   = (val_x > MAX_AMT_X) ? MAX_AMT_X : val_x;
  assign coin_x  = CMP_W'(req.operand_value & COIN_MASK);
  // pass runs only for a coin in 1..amount
  assign coin_ok = (coin_x != '0) && (coin_x <= CMP_W'(target));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (req.req_type == REQ_START) begin
            state_next = S_CLEAR;
          end else if (coin_ok) begin
            state_next = S_PASS;
          end else if (req.last_item) begin
            state_next = S_READ;
          end
        end
      end
      S_CLEAR: begin
        if (idx == target) begin
          state_next = last_pend ? S_READ : S_IDLE;
        end
      end
      S_PASS: begin
        // last read issue of the pass
        if (idx == target) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: state_next = last_pend ? S_READ : S_IDLE;
      S_READ:  state_next = S_EMIT;
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      target    <= '0;
      ovf_seen  <= 1'b0;
      last_pend <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == S_PASS);
      if (take) begin
        last_pend <= req.last_item;
        if (req.req_type == REQ_START) begin
          target   <= amt_x[AW-1:0];
          ovf_seen <= 1'b0;
        end
      end
      if (s1_valid && sum_ovf) begin
        ovf_seen <= 1'b1;
      end
    end
  end

  // index, coin and pipeline payload
  always_ff @(posedge clk) begin
    if (take) begin
      coin <= coin_x[AW-1:0];
      // sweep starts at entry 0, a pass at entry coin
      idx  <= (req.req_type == REQ_START) ? '0 : coin_x[AW-1:0];
    end else if (state == S_CLEAR || state == S_PASS) begin
      idx <= idx + AW'(1);
    end
    s1_idx <= idx;
    s1_fwd <= s1_valid && (raddr_b == s1_idx);
    if (s1_valid) begin
      last_wdata <= sum;
    end
  end

  // ---------------------------------------------------------------- datapath
  // reads: entry n and entry n-coin during a pass, entry target for readout
  assign raddr_a = (state == S_READ) ? target : idx;
  assign raddr_b = idx - coin;

  // a write issued in the same cycle as the read is not seen by the ram
  // read, so the low operand takes the value written in the previous cycle
  assign lo_op = s1_fwd ? last_wdata : rdata_b;

  ccw_sat_add #(
    .WIDTH (COUNT_WIDTH)
  ) u_add (
    .a   (rdata_a),
    .b   (lo_op),
    .sum (sum),
    .ovf (sum_ovf)
  );

  // write mux: clear sweep or pass update
  always_comb begin
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = idx;
      wdata = (idx == '0) ? COUNT_WIDTH'(1) : '0;
    end else begin
      we    = s1_valid;
      waddr = s1_idx;
      wdata = sum;
    end
  end

  ccw_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // ---------------------------------------------------------------- result
  // clip wide counts to the 32-bit result field
  assign rd_ext        = EXT_W'(rdata_a);
  assign clip          = |rd_ext[EXT_W-1:WAYS_W];
  assign done          = (state == S_EMIT);
  assign rsp.ways      = clip ? {WAYS_W{1'b1}} : rd_ext[WAYS_W-1:0];
  assign rsp.saturated = ovf_seen || clip;

endmodule

FILE: rtl/ccw_checker.sv
// port-level checks for the coin change ways counter, bound to the top level
module ccw_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ccw_pkg::req_t req,
  input logic          done,
  input ccw_pkg::rsp_t rsp
);
  import ccw_pkg::*;

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("block not idle after reset");

  // a result is never shown in the cycle right after a transfer
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result right after transfer");

  // a start item always runs a clear sweep
  a_start_sweeps: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type == REQ_START)) |=> busy)
    else $error("start item finished without sweep");

  // a result belongs to an item still in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result while idle");

  // the strobe lasts one cycle and frees the block
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

endmodule

bind coin_change_ways_counter ccw_checker u_ccw_checker (.*);
